>>> design/lsfs_pkg.sv
// Shared types, codes and constants of the LED strip frame store and serializer.
package lsfs_pkg;

   localparam int STRIP_LEDS_DEF = 60;
   localparam logic [5:0] LED_COUNT_RST = 6'd60;

   localparam logic [31:0] START_WORD = 32'h0000_0000;
   localparam logic [31:0] END_WORD   = 32'hFFFF_FFFF;
   localparam logic [31:0] BLANK_WORD = 32'hFF00_0000;

   // item modes
   localparam logic [1:0] MODE_STORE = 2'd0;
   localparam logic [1:0] MODE_SHOW  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // word kinds selected by the controller
   localparam logic [1:0] WORD_START = 2'd0;
   localparam logic [1:0] WORD_LED   = 2'd1;
   localparam logic [1:0] WORD_END   = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] led_index;
      logic [7:0] brightness_in;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] frame_word;
      logic        last_word;
   } rsp_payload_type;

   typedef struct packed {
      logic       store_we;
      logic       clear_all;
      logic       idx_rst;
      logic       idx_inc;
      logic       emit;
      logic [1:0] word_kind;
      logic       last;
      logic       blank;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic cnt_zero;
      logic last_led;
      logic lit_next;
   } dp_status_type;

endpackage

>>> design/lsfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 60,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/lsfs_dp.sv
// Datapath: LED store with valid bits, frame index, lit flag, count register, output register.
module lsfs_dp
   import lsfs_pkg::*;
#(
   parameter int STRIP_LEDS = STRIP_LEDS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  logic            csr_valid,
   input  logic [5:0]      csr_data,
   input  ctrl_cmd_type    cmd,
   output dp_status_type   sts,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int IDX_W = (STRIP_LEDS > 1) ? $clog2(STRIP_LEDS) : 1;
   localparam int CNT_W = $clog2(STRIP_LEDS + 1);

   logic [5:0]            count_ff, count_in;
   logic [CNT_W-1:0]      cnt;
   logic [CNT_W-1:0]      idx_ff, idx_in, idx_nxt;
   logic [STRIP_LEDS-1:0] valid_ff, valid_in;
   logic                  lit_ff, lit_in;
   logic                  led_lit;
   logic                  in_range;
   logic [31:0]           ram_rd;
   logic [31:0]           word;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   assign in_range = (req_data.led_index < 6'(STRIP_LEDS));

   lsfs_ram #(
      .WIDTH (32),
      .DEPTH (STRIP_LEDS)
   ) u_store (
      .clock (clock),
      .we    (cmd.store_we && in_range),
      .waddr (req_data.led_index[IDX_W-1:0]),
      .wdata ({req_data.brightness_in, req_data.blue, req_data.green, req_data.red}),
      .raddr (idx_in[IDX_W-1:0]),
      .rdata (ram_rd)
   );

   // counts above the strip length clamp to it
   assign cnt = (count_ff > 6'(STRIP_LEDS)) ? CNT_W'(STRIP_LEDS) : CNT_W'(count_ff);
   assign count_in = csr_valid ? csr_data : count_ff;

   assign idx_nxt = idx_ff + CNT_W'(1);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_rst) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_nxt;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.store_we && in_range) begin
         valid_in[req_data.led_index[IDX_W-1:0]] = 1'b1;
      end
   end

   // read data lines up with idx_ff: the address is the index's next value
   assign led_lit = !cmd.blank && valid_ff[idx_ff[IDX_W-1:0]] && (ram_rd[31:24] != 8'd0);

   always_comb begin
      lit_in = lit_ff;
      if (cmd.idx_rst) begin
         lit_in = 1'b0;
      end else if (cmd.emit && (cmd.word_kind == WORD_LED)) begin
         lit_in = lit_ff | led_lit;
      end
   end

   always_comb begin
      unique case (cmd.word_kind)
         WORD_START: word = START_WORD;
         WORD_LED:   word = led_lit ? ram_rd : BLANK_WORD;
         WORD_END:   word = END_WORD;
         default:    word = START_WORD;
      endcase
   end

   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;
   assign sts.cnt_zero  = (cnt == '0);
   assign sts.last_led  = (idx_nxt == cnt);
   assign sts.lit_next  = lit_ff | led_lit;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_in.frame_word = word;
         rsp_in.last_word  = cmd.last;
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= LED_COUNT_RST;
         idx_ff       <= '0;
         valid_ff     <= '0;
         lit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         lit_ff       <= lit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/lsfs_ctrl.sv
// Controller: frame sequencing state machine.
module lsfs_ctrl
   import lsfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   input  dp_status_type   sts,
   output ctrl_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_LEDS  = 2'd2;
   localparam logic [1:0] ST_END   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       blank_ff, blank_in;
   logic       req_acc;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd       = '0;
      cmd.blank = blank_ff;
      state_in  = state_ff;
      blank_in  = blank_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_data.mode)
                  MODE_STORE: cmd.store_we = 1'b1;
                  MODE_SHOW: begin
                     cmd.idx_rst = 1'b1;
                     blank_in    = 1'b0;
                     state_in    = ST_START;
                  end
                  MODE_CLEAR: begin
                     cmd.clear_all = 1'b1;
                     cmd.idx_rst   = 1'b1;
                     blank_in      = 1'b1;
                     state_in      = ST_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_START: begin
            if (sts.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.word_kind = WORD_START;
               if (sts.cnt_zero) begin
                  cmd.last = !blank_ff;
                  state_in = blank_ff ? ST_END : ST_IDLE;
               end else begin
                  state_in = ST_LEDS;
               end
            end
         end
         ST_LEDS: begin
            if (sts.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.word_kind = WORD_LED;
               cmd.idx_inc   = 1'b1;
               if (sts.last_led) begin
                  cmd.last = !sts.lit_next && !blank_ff;
                  state_in = (sts.lit_next || blank_ff) ? ST_END : ST_IDLE;
               end
            end
         end
         ST_END: begin
            if (sts.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.word_kind = WORD_END;
               cmd.last      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         blank_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         blank_ff <= blank_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.slot_free)
      else $error("word emitted while output register full");

   a_frame_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && ((req_data.mode == MODE_SHOW) || (req_data.mode == MODE_CLEAR)))
      |=> (state_ff == ST_START))
      else $error("frame transaction did not start a frame");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("frame continued after last word");

   a_store_idle_only: assert property (@(posedge clock) disable iff (reset)
      (cmd.store_we || cmd.clear_all) |-> (state_ff == ST_IDLE))
      else $error("store changed during a frame");
`endif

endmodule

>>> design/led_strip_frame_store_serializer.sv
// Top level of the LED strip frame store and serializer.
// Keeps one 32-bit entry (brightness, blue, green, red) per LED, all blank after
// reset, and turns it into an SPI LED frame on the rsp channel. A store
// transaction (mode 0) writes one entry; an index at or above STRIP_LEDS is
// dropped with no response. A display transaction (mode 1) sends a zero start
// word, one word per LED for the first led_count entries (blank entries, never
// written since reset or clear or with brightness zero, go out as FF000000),
// then an all-ones end word only if some sent entry was lit. A clear transaction
// (mode 2) marks the whole store blank at once and sends the start word,
// led_count blank words and the end word. last_word marks the final word of
// each frame. Mode 3 is ignored. led_count is written through the csr port,
// resets to 60 and is clamped to STRIP_LEDS; it may only be changed while no
// frame is in flight. A frame transaction runs through the accept cycle, start
// word, LED words and any end word, req_stall high in all but the accept cycle,
// one word per cycle as long as rsp_stall is low. The final word sits in the
// output register, so the next transaction is accepted while it waits.
module led_strip_frame_store_serializer
   import lsfs_pkg::*;
#(
   parameter int STRIP_LEDS = STRIP_LEDS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   // input transactions
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   // frame words
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   // led_count register
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [5:0]      csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   lsfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .sts       (sts),
      .cmd       (cmd)
   );

   lsfs_dp #(
      .STRIP_LEDS (STRIP_LEDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
